@@ design/fixed_point_alu_q24_8_unit_macros.svh @@
// Assertion macros for the fixed-point ALU unit.
// No dependencies; included by the top level only.
`ifndef FIXED_POINT_ALU_Q24_8_UNIT_MACROS_SVH
`define FIXED_POINT_ALU_Q24_8_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define FPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fpa assertion failed");
// checked during reset too
`define FPA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fpa assertion failed");
`else
`define FPA_ASSERT(lbl, clk, rst_n, prop)
`define FPA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ design/fpa_pkg.sv @@
// Shared types and opcodes for the fixed-point ALU unit.
// No dependencies.
package fpa_pkg;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MIN = 4'd4,
        OP_MAX = 4'd5,
        OP_INC = 4'd6,
        OP_DEC = 4'd7,
        OP_I2F = 4'd8,
        OP_F2I = 4'd9
    } fpa_op_t;

    // Everything except the quotient, carried beside the divider
    typedef struct packed {
        logic [31:0] value;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        dz;
        logic        is_div;
        logic        neg;
    } fpa_side_t;

    // One finished result
    typedef struct packed {
        logic        dz;
        logic        gt;
        logic        eq;
        logic        lt;
        logic [31:0] value;
    } fpa_res_t;

endpackage

@@ design/fixed_point_alu_q24_8_unit.sv @@
// Top level of the pipelined signed fixed-point ALU (Q24.8 by default).
// Depends on fpa_pkg, fpa_front, fpa_div_pipe, fpa_out_buf and the macros header.
//
// Usage:
//   Input stream s_*: one operation per transfer; tdata = opcode, operand_a,
//   operand_b. Result stream m_*: one result per operation, in order;
//   tdata = result_value, a_less, a_equal, a_greater, divide_by_zero.
//   Ops: add, sub, mul (product >>> FRAC_BITS), div ((a << FRAC_BITS) / b,
//   toward zero, zero result and flag on b == 0), min, max, inc, dec,
//   int-to-fixed, fixed-to-int. Undefined opcodes give 0. All results wrap.
//   Throughput: one transfer per cycle, sustained, for any opcode mix, while
//   the output buffer has a free slot (see Stall). Path from input transfer
//   to m_tvalid: one front stage, 32 + FRAC_BITS divider stages
//   (one quotient bit each) and the output buffer. All ops share that path.
//   Reset (aresetn low, synchronous) empties the pipeline and output buffer.
//   Stall: a two-entry buffer holds results; s_tready drops only when it
//   is full, and the whole pipeline freezes in place until m_tready frees
//   a slot. Nothing is lost or repeated.
`include "fixed_point_alu_q24_8_unit_macros.svh"

module fixed_point_alu_q24_8_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] opcode, [35:4] operand_a, [67:36] operand_b, [71:68] zero
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] result_value, [32] a_less, [33] a_equal, [34] a_greater,
    // [35] divide_by_zero, [39:36] zero
    output logic [39:0] m_tdata
);
    import fpa_pkg::*;

    localparam int NumW = 32 + FRAC_BITS;

    logic            en;
    logic            f_valid, d_valid;
    fpa_side_t       f_side, d_side;
    logic [NumW-1:0] f_num, d_quot;
    logic [31:0]     f_den, q32, div_val;
    fpa_res_t        res, head;
    logic            buf_not_full;

    // whole pipeline moves together while the buffer has a free slot
    assign en       = buf_not_full;
    assign s_tready = en;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .opcode    (s_tdata[3:0]),
        .operand_a (s_tdata[35:4]),
        .operand_b (s_tdata[67:36]),
        .out_valid (f_valid),
        .side      (f_side),
        .num       (f_num),
        .den       (f_den)
    );

    fpa_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_num    (f_num),
        .in_den    (f_den),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_quot  (d_quot)
    );

    // sign fix of the quotient; only its low 32 bits matter after wrap
    assign q32     = d_quot[31:0];
    assign div_val = d_side.neg ? (32'd0 - q32) : q32;

    always_comb begin
        res.lt    = d_side.lt;
        res.eq    = d_side.eq;
        res.gt    = d_side.gt;
        res.dz    = d_side.dz;
        res.value = d_side.value;
        if (d_side.is_div) begin
            res.value = d_side.dz ? 32'd0 : div_val;
        end
    end

    fpa_out_buf u_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (en && d_valid),
        .push_data (res),
        .pop       (m_tready),
        .not_empty (m_tvalid),
        .not_full  (buf_not_full),
        .head      (head)
    );

    assign m_tdata = {4'd0, head};

    // exactly one compare outcome per result
    `FPA_ASSERT(a_flags_onehot, aclk, aresetn, m_tvalid |-> $onehot(m_tdata[34:32]))
    // a division by zero always reads back as zero
    `FPA_ASSERT(a_dz_zero, aclk, aresetn, (m_tvalid && m_tdata[35]) |-> (m_tdata[31:0] == 32'd0))
    // reset leaves no result pending
    `FPA_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

@@ design/fpa_front.sv @@
// First stage: decode, compare, multiply and simple ops; divider operand setup.
// Depends on fpa_pkg.
module fpa_front #(
    parameter int FRAC_BITS = 8,
    localparam int NumW = 32 + FRAC_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [3:0]              opcode,
    input  logic signed [31:0]      operand_a,
    input  logic signed [31:0]      operand_b,
    output logic                    out_valid,
    output fpa_pkg::fpa_side_t      side,
    output logic [NumW-1:0]         num,
    output logic [31:0]             den
);
    import fpa_pkg::*;

    logic               valid_reg;
    fpa_side_t          side_reg, side_next;
    logic [NumW-1:0]    num_reg;
    logic [31:0]        den_reg;
    logic signed [63:0] prod;
    logic [31:0]        mag_a, mag_b;

    assign prod  = operand_a * operand_b;
    assign mag_a = operand_a[31] ? (32'd0 - operand_a) : operand_a;
    assign mag_b = operand_b[31] ? (32'd0 - operand_b) : operand_b;

    always_comb begin
        side_next        = '0;
        side_next.lt     = operand_a < operand_b;
        side_next.eq     = operand_a == operand_b;
        side_next.gt     = operand_a > operand_b;
        side_next.neg    = operand_a[31] ^ operand_b[31];
        case (fpa_op_t'(opcode))
            OP_ADD: side_next.value = operand_a + operand_b;
            OP_SUB: side_next.value = operand_a - operand_b;
            OP_MUL: side_next.value = prod[FRAC_BITS+31:FRAC_BITS];
            OP_DIV: begin
                side_next.is_div = 1'b1;
                side_next.dz     = operand_b == 32'sd0;
            end
            OP_MIN: side_next.value = (operand_a < operand_b) ? operand_a : operand_b;
            OP_MAX: side_next.value = (operand_a > operand_b) ? operand_a : operand_b;
            OP_INC: side_next.value = operand_a + 32'sd1;
            OP_DEC: side_next.value = operand_a - 32'sd1;
            OP_I2F: side_next.value = operand_a << FRAC_BITS;
            OP_F2I: side_next.value = operand_a >>> FRAC_BITS;
            default: side_next.value = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            num_reg  <= {mag_a, {FRAC_BITS{1'b0}}};
            den_reg  <= mag_b;
        end
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;
    assign num       = num_reg;
    assign den       = den_reg;

endmodule

@@ design/fpa_div_pipe.sv @@
// Restoring divider, one quotient bit per register stage; side data rides along.
// Depends on fpa_pkg.
module fpa_div_pipe #(
    parameter int FRAC_BITS = 8,
    localparam int NumW = 32 + FRAC_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  fpa_pkg::fpa_side_t      in_side,
    input  logic [NumW-1:0]         in_num,
    input  logic [31:0]             in_den,
    output logic                    out_valid,
    output fpa_pkg::fpa_side_t      out_side,
    output logic [NumW-1:0]         out_quot
);
    import fpa_pkg::*;

    // index 0 is the stage input; index k is the register after step k
    logic            vld_reg  [NumW+1];
    fpa_side_t       side_reg [NumW+1];
    logic [NumW-1:0] num_reg  [NumW+1];
    logic [31:0]     den_reg  [NumW+1];
    logic [31:0]     rem_reg  [NumW+1];

    assign vld_reg[0]  = in_valid;
    assign side_reg[0] = in_side;
    assign num_reg[0]  = in_num;
    assign den_reg[0]  = in_den;
    assign rem_reg[0]  = '0;

    for (genvar k = 1; k <= NumW; k++) begin : g_step
        logic [32:0] shifted, diff;
        logic        ge;

        assign shifted = {rem_reg[k-1], num_reg[k-1][NumW-1]};
        assign diff    = shifted - {1'b0, den_reg[k-1]};
        assign ge      = !diff[32];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                num_reg[k]  <= {num_reg[k-1][NumW-2:0], ge};
                rem_reg[k]  <= ge ? diff[31:0] : shifted[31:0];
            end
        end
    end

    assign out_valid = vld_reg[NumW];
    assign out_side  = side_reg[NumW];
    assign out_quot  = num_reg[NumW];

endmodule

@@ design/fpa_out_buf.sv @@
// Two-entry output buffer; decouples the pipeline from the result receiver.
// Depends on fpa_pkg.
module fpa_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  fpa_pkg::fpa_res_t  push_data,
    input  logic               pop,
    output logic               not_empty,
    output logic               not_full,
    output fpa_pkg::fpa_res_t  head
);
    import fpa_pkg::*;

    fpa_res_t   mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_pop;

    assign not_empty = count_reg != 2'd0;
    assign not_full  = count_reg != 2'd2;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ verif/fixed_point_alu_q24_8_unit_tb.sv @@
// Self-checking testbench for the fixed-point ALU unit (Q24.8).
// Depends on fpa_pkg and fixed_point_alu_q24_8_unit; drives random and directed operations.
module fixed_point_alu_q24_8_unit_tb;
    import fpa_pkg::*;

    localparam int FRAC = 8;

    typedef struct {
        logic [3:0]  opcode;
        logic [31:0] opa;
        logic [31:0] opb;
    } alu_op_t;

    typedef struct {
        logic [31:0] value;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        dz;
    } alu_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    alu_op_t  op_queue[$];
    alu_res_t expected_results[$];
    int       mismatches = 0;
    int       results_seen = 0;
    int       ops_sent = 0;
    bit       stim_done = 1'b0;
    bit       quiet_phase = 1'b0;
    int       src_gap = 0;
    int       sink_gap = 0;

    fixed_point_alu_q24_8_unit #(.FRAC_BITS(FRAC)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Golden ALU behavior
    function automatic alu_res_t alu_predict(alu_op_t op);
        alu_res_t          r;
        logic signed [31:0] a, b;
        logic signed [63:0] prod;
        logic [63:0]        num, den, quo;
        a = op.opa;
        b = op.opb;
        r.lt = a < b;
        r.eq = a == b;
        r.gt = a > b;
        r.dz = 1'b0;
        r.value = '0;
        case (op.opcode)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: begin
                prod = 64'(a) * 64'(b);
                r.value = 32'(prod >>> FRAC);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    num = 64'(a < 0 ? -64'(a) : 64'(a)) << FRAC;
                    den = (b < 0) ? -64'(b) : 64'(b);
                    quo = num / den;
                    r.value = 32'((a[31] ^ b[31]) ? -quo : quo);
                end
            end
            OP_MIN: r.value = (a < b) ? a : b;
            OP_MAX: r.value = (a > b) ? a : b;
            OP_INC: r.value = a + 1;
            OP_DEC: r.value = a - 1;
            OP_I2F: r.value = a << FRAC;
            OP_F2I: r.value = a >>> FRAC;
            default: r.value = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %h want %h", results_seen, what, got, want);
        mismatches++;
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 4) - 2;
            3: return 32'(int'($urandom_range(0, 65535)) - 32768);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_op(logic [3:0] opc, logic [31:0] a, logic [31:0] b);
        alu_op_t op;
        op.opcode = opc;
        op.opa = a;
        op.opb = b;
        op_queue.push_back(op);
    endtask

    // Driver: expectation is queued when the transfer completes
    always @(posedge aclk) begin
        alu_op_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                op.opcode = s_tdata[3:0];
                op.opa = s_tdata[35:4];
                op.opb = s_tdata[67:36];
                expected_results.push_back(alu_predict(op));
                ops_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    op = op_queue.pop_front();
                    s_tdata <= {4'b0, op.opb, op.opa, op.opcode};
                    s_tvalid <= 1'b1;
                    if (!quiet_phase && $urandom_range(0, 9) == 0)
                        src_gap = $urandom_range(1, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor and sink backpressure
    always @(posedge aclk) begin
        alu_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer", m_tdata[31:0], 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.value)
                        report_mismatch("result_value", m_tdata[31:0], want.value);
                    if (m_tdata[32] !== want.lt) report_mismatch("a_less", m_tdata[32], want.lt);
                    if (m_tdata[33] !== want.eq) report_mismatch("a_equal", m_tdata[33], want.eq);
                    if (m_tdata[34] !== want.gt)
                        report_mismatch("a_greater", m_tdata[34], want.gt);
                    if (m_tdata[35] !== want.dz)
                        report_mismatch("divide_by_zero", m_tdata[35], want.dz);
                end
                results_seen++;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 9) == 0)
                    sink_gap = $urandom_range(1, 5);
            end
        end
    end

    initial begin
        logic [31:0] ext[6];
        ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100, 32'hffff_ff00};
        // directed: extremes per op, zero divisor, undefined opcodes
        for (int k = 0; k <= 9; k++) push_op(4'(k), ext[k % 6], ext[(k + 1) % 6]);
        push_op(OP_DIV, 32'h7fff_ffff, 32'h0);
        push_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        push_op(OP_DIV, 32'h8000_0000, 32'h1);
        push_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        push_op(OP_MUL, 32'hffff_ffff, 32'h1);
        push_op(OP_F2I, 32'hffff_ffff, 32'h0);
        push_op(OP_MIN, 32'h5, 32'h5);
        push_op(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
        push_op(OP_INC, 32'h7fff_ffff, 32'h0);
        push_op(OP_DEC, 32'h8000_0000, 32'h0);
        push_op(4'd10, 32'h1, 32'h2);
        push_op(4'd15, 32'hffff_ffff, 32'hffff_ffff);
        push_op(OP_I2F, 32'h00ff_ffff, 32'h0);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        for (int n = 0; n < 1950; n++) begin
            logic [3:0] opc;
            logic [31:0] b;
            opc = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
            b = ($urandom_range(0, 15) == 0) ? 32'h0 : rand_operand();
            push_op(opc, rand_operand(), b);
            if (n == 1700) begin
                // drain then run the tail without bubbles
                wait (op_queue.size() == 0);
                quiet_phase = 1'b1;
            end
        end
        wait (op_queue.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (60) @(posedge aclk);
        $display("covered %0d operations, %0d results,", ops_sent, results_seen);
        $display("all opcodes incl. undefined and zero divisor, with stalls on both sides");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("CHECK FAILED");
        $finish;
    end
endmodule
